FILE: rtl/vs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_pkg
// shared sizes, payload types and limits for the vector standardizer
// ----------------------------------------------------------------------------
package vs_pkg;

    localparam int MAX_LEN = 64;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = $clog2(MAX_LEN + 1);

    // arithmetic widths
    localparam int SUM_W  = 16 + CW;
    localparam int Q_W    = 31 + CW;
    localparam int T_W    = Q_W + CW;
    localparam int NT_W   = T_W + CW;
    localparam int D_W    = 18 + CW;
    localparam int DIV_W  = 64;
    localparam int SQRT_W = DIV_W / 2;
    localparam int STAT_W = 27;
    localparam int ELEM_W = 24;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 24'sh7FFFFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_out;
        logic [STAT_W-1:0]        statistic;
        logic                     zero_spread_error;
        logic                     last_out;
    } out_item_t;

endpackage

FILE: rtl/vs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module vs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/vs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vs_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [vs_pkg::DIV_W-1:0] dividend,
    input  logic [vs_pkg::DIV_W-1:0] divisor,
    output logic                     done,
    output logic [vs_pkg::DIV_W-1:0] quotient
);
    import vs_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/vs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_sqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module vs_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [vs_pkg::DIV_W-1:0]  radicand,
    output logic                      done,
    output logic [vs_pkg::SQRT_W-1:0] root
);
    import vs_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] v_reg, v_next;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] b_reg, b_next;
    logic [DIV_W-1:0] rb;

    assign rb = r_reg + b_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = radicand;
            r_next    = '0;
            b_next    = DIV_W'(1) << (DIV_W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= rb)
            begin
                v_next = v_reg - rb;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            if (b_reg == DIV_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[SQRT_W-1:0];

endmodule

FILE: rtl/vector_standardizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_standardizer_core
// loads a vector of q8.8 samples and emits it standardized in q8.16
// ----------------------------------------------------------------------------
// loading: one sample request per cycle, in_stall low while idle
// mean mode: a statistics pass, then the statistic and scale roots, then an
//   output pass through the bit-serial divider; a zero spread gives one result
// min-max mode: two passes through the divider with the two roots between them;
//   a zero spread bypasses the divider
// rst_n clears sequencer, counters, min/max and output valid; store not cleared
module vector_standardizer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  vs_pkg::in_item_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output vs_pkg::out_item_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import vs_pkg::*;

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RD   = 5'd1;   // store read in flight
    localparam logic [4:0] ST_PREP = 5'd2;   // per-element setup
    localparam logic [4:0] ST_DIVW = 5'd3;   // element division
    localparam logic [4:0] ST_VAL  = 5'd4;   // element value ready
    localparam logic [4:0] ST_EMIT = 5'd5;   // hand result to output reg
    localparam logic [4:0] ST_NQ   = 5'd6;   // n * sum of squares
    localparam logic [4:0] ST_SS   = 5'd7;   // sum squared
    localparam logic [4:0] ST_TT   = 5'd8;   // n times the centered sum of squares
    localparam logic [4:0] ST_STW1 = 5'd9;   // t * 2^16 / n
    localparam logic [4:0] ST_STW2 = 5'd10;  // root of that, the statistic
    localparam logic [4:0] ST_NT   = 5'd11;  // n * t
    localparam logic [4:0] ST_RTW  = 5'd12;  // scale root
    localparam logic [4:0] ST_N1W  = 5'd13;  // root of output sum of squares
    localparam logic [4:0] ST_N2W  = 5'd14;  // root of norm, the statistic
    localparam logic [4:0] ST_ERR  = 5'd15;  // zero spread error result

    localparam logic MODE_MEAN   = 1'b0;
    localparam logic MODE_MINMAX = 1'b1;

    localparam logic signed [15:0] MIN_INIT = 16'sh7FFF;
    localparam logic signed [15:0] MAX_INIT = 16'sh8000;

    // control state
    logic [4:0]              state_reg, state_next;
    logic                    mode_reg, mode_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [15:0]      min_reg, min_next;
    logic signed [15:0]      max_reg, max_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic                    pass_reg, pass_next;   // 0 statistics pass, 1 output pass
    logic                    div_start_reg, div_start_next;
    logic                    sqrt_start_reg, sqrt_start_next;
    logic                    out_valid_reg, out_valid_next;

    // datapath registers
    logic [DIV_W-1:0]         acc_reg, acc_next;
    logic [T_W-1:0]           nq_reg, nq_next;
    logic [T_W-1:0]           ss_reg, ss_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic [SQRT_W-1:0]        root_reg, root_next;
    logic [STAT_W-1:0]        stat_reg, stat_next;
    logic signed [ELEM_W-1:0] val_reg, val_next;
    logic                     dneg_reg, dneg_next;
    logic [DIV_W-1:0]         div_a_reg, div_a_next;
    logic [DIV_W-1:0]         div_b_reg, div_b_next;
    logic [DIV_W-1:0]         sqrt_a_reg, sqrt_a_next;
    out_item_t                out_reg, out_next;

    // shared units and store
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    logic                sqrt_done;
    logic [SQRT_W-1:0]   sqrt_r;
    logic                ram_we;
    logic [15:0]         ram_rd;

    // element arithmetic
    logic signed [15:0]        x;
    logic signed [31:0]        xx;
    logic signed [CW:0]        n_s;
    logic signed [CW+16:0]     nx;
    logic signed [D_W-1:0]     d_val;
    logic signed [D_W-1:0]     d_mag;
    logic signed [16:0]        xm;
    logic signed [16:0]        spread;
    logic signed [47:0]        vv;
    logic [T_W-1:0]            nq_full;
    logic signed [2*SUM_W-1:0] ss_full;
    logic [NT_W-1:0]           nt_full;
    logic signed [ELEM_W-1:0]  elem_sat;

    // handshake
    logic in_fire;
    logic close_vec;
    logic last_idx;
    logic out_free;

    function automatic logic [Q_W-1:0] q_width(input logic [DIV_W-1:0] a);
        q_width = a[Q_W-1:0];
    endfunction

    assign x       = $signed(ram_rd);
    assign xx      = x * x;
    assign n_s     = $signed({1'b0, count_reg});
    assign nx      = n_s * x;
    assign d_val   = D_W'(nx) - D_W'(sum_reg);
    assign d_mag   = d_val[D_W-1] ? -d_val : d_val;
    assign xm      = x - min_reg;
    assign spread  = max_reg - min_reg;
    assign vv      = val_reg * val_reg;
    assign nq_full = count_reg * q_width(acc_reg);
    assign ss_full = sum_reg * sum_reg;
    assign nt_full = count_reg * t_reg;

    // divider result to signed element, saturated to the output range
    always_comb
    begin
        if (|div_q[DIV_W-1:ELEM_W-1])
        begin
            elem_sat = dneg_reg ? ELEM_MIN : ELEM_MAX;
        end
        else
        begin
            elem_sat = dneg_reg ? -$signed(div_q[ELEM_W-1:0])
                                :  $signed(div_q[ELEM_W-1:0]);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign close_vec = in_data.last_in || (count_reg == CW'(MAX_LEN - 1));
    assign last_idx  = (CW'(idx_reg) == count_reg - CW'(1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_we    = in_fire;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        div_start_next  = 1'b0;
        sqrt_start_next = 1'b0;
        acc_next        = acc_reg;
        nq_next         = nq_reg;
        ss_next         = ss_reg;
        t_next          = t_reg;
        root_next       = root_reg;
        stat_next       = stat_reg;
        val_next        = val_reg;
        dneg_next       = dneg_reg;
        div_a_next      = div_a_reg;
        div_b_next      = div_b_reg;
        sqrt_a_next     = sqrt_a_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    count_next = count_reg + CW'(1);
                    sum_next   = sum_reg + SUM_W'(in_data.sample);
                    if (in_data.sample < min_reg)
                    begin
                        min_next = in_data.sample;
                    end
                    if (in_data.sample > max_reg)
                    begin
                        max_next = in_data.sample;
                    end
                    if (close_vec)
                    begin
                        idx_next   = '0;
                        pass_next  = 1'b0;
                        acc_next   = '0;
                        state_next = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                if (mode_reg == MODE_MEAN)
                begin
                    if (!pass_reg)
                    begin
                        // sum of squares, then advance
                        acc_next = acc_reg + DIV_W'($unsigned(xx));
                        if (last_idx)
                        begin
                            state_next = ST_NQ;
                        end
                        else
                        begin
                            idx_next   = idx_reg + AW'(1);
                            state_next = ST_RD;
                        end
                    end
                    else
                    begin
                        dneg_next      = d_val[D_W-1];
                        div_a_next     = DIV_W'($unsigned(d_mag)) << 23;
                        div_b_next     = DIV_W'(root_reg);
                        div_start_next = 1'b1;
                        state_next     = ST_DIVW;
                    end
                end
                else
                begin
                    if (spread != 17'sd0)
                    begin
                        div_a_next     = DIV_W'($unsigned(xm)) << 16;
                        div_b_next     = DIV_W'($unsigned(spread));
                        div_start_next = 1'b1;
                        state_next     = ST_DIVW;
                    end
                    else
                    begin
                        // flat vector passes through rescaled to q8.16
                        val_next   = $signed({x, 8'h00});
                        state_next = ST_VAL;
                    end
                end
            end

            ST_DIVW:
            begin
                if (div_done)
                begin
                    val_next   = (mode_reg == MODE_MEAN) ? elem_sat
                                                         : $signed(div_q[ELEM_W-1:0]);
                    state_next = ST_VAL;
                end
            end

            ST_VAL:
            begin
                if (pass_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    acc_next = acc_reg + DIV_W'($unsigned(vv));
                    if (last_idx)
                    begin
                        sqrt_a_next     = acc_reg + DIV_W'($unsigned(vv));
                        sqrt_start_next = 1'b1;
                        state_next      = ST_N1W;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_next.element_out       = val_reg;
                    out_next.statistic         = stat_reg;
                    out_next.zero_spread_error = 1'b0;
                    out_next.last_out          = last_idx;
                    if (last_idx)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        min_next   = MIN_INIT;
                        max_next   = MAX_INIT;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_NQ:
            begin
                nq_next    = nq_full;
                state_next = ST_SS;
            end

            ST_SS:
            begin
                ss_next    = T_W'($unsigned(ss_full));
                state_next = ST_TT;
            end

            ST_TT:
            begin
                t_next = nq_reg - ss_reg;
                if (nq_reg == ss_reg)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    div_a_next     = DIV_W'(nq_reg - ss_reg) << 16;
                    div_b_next     = DIV_W'(count_reg);
                    div_start_next = 1'b1;
                    state_next     = ST_STW1;
                end
            end

            ST_STW1:
            begin
                if (div_done)
                begin
                    sqrt_a_next     = div_q;
                    sqrt_start_next = 1'b1;
                    state_next      = ST_STW2;
                end
            end

            ST_STW2:
            begin
                if (sqrt_done)
                begin
                    stat_next  = sqrt_r[STAT_W-1:0];
                    state_next = ST_NT;
                end
            end

            ST_NT:
            begin
                sqrt_a_next     = DIV_W'(nt_full) << 14;
                sqrt_start_next = 1'b1;
                state_next      = ST_RTW;
            end

            ST_RTW:
            begin
                if (sqrt_done)
                begin
                    root_next  = sqrt_r;
                    idx_next   = '0;
                    pass_next  = 1'b1;
                    state_next = ST_RD;
                end
            end

            ST_N1W:
            begin
                if (sqrt_done)
                begin
                    sqrt_a_next     = DIV_W'(sqrt_r) << 16;
                    sqrt_start_next = 1'b1;
                    state_next      = ST_N2W;
                end
            end

            ST_N2W:
            begin
                if (sqrt_done)
                begin
                    stat_next  = sqrt_r[STAT_W-1:0];
                    idx_next   = '0;
                    pass_next  = 1'b1;
                    state_next = ST_RD;
                end
            end

            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_next.element_out       = '0;
                    out_next.statistic         = '0;
                    out_next.zero_spread_error = 1'b1;
                    out_next.last_out          = 1'b1;
                    count_next = '0;
                    sum_next   = '0;
                    min_next   = MIN_INIT;
                    max_next   = MAX_INIT;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_MEAN;
            count_reg      <= '0;
            sum_reg        <= '0;
            min_reg        <= MIN_INIT;
            max_reg        <= MAX_INIT;
            idx_reg        <= '0;
            pass_reg       <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            idx_reg        <= idx_next;
            pass_reg       <= pass_next;
            div_start_reg  <= div_start_next;
            sqrt_start_reg <= sqrt_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        nq_reg     <= nq_next;
        ss_reg     <= ss_next;
        t_reg      <= t_next;
        root_reg   <= root_next;
        stat_reg   <= stat_next;
        val_reg    <= val_next;
        dneg_reg   <= dneg_next;
        div_a_reg  <= div_a_next;
        div_b_reg  <= div_b_next;
        sqrt_a_reg <= sqrt_a_next;
        out_reg    <= out_next;
    end

    // element store, written while loading, read one entry per pass step
    vs_ram #(
        .WIDTH (16),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_data.sample),
        .rd_addr (idx_reg),
        .rd_data (ram_rd)
    );

    // shared divider: statistic scaling and every element quotient
    vs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // shared root unit: statistic, scale and norm roots
    vs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_a_reg),
        .done     (sqrt_done),
        .root     (sqrt_r)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/vs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_checker
// port-level checks for the vector standardizer
// ----------------------------------------------------------------------------
module vs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input vs_pkg::in_item_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input vs_pkg::out_item_t out_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // closing sample stops loading
    a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.last_in |=> in_stall)
        else $error("request taken right after closing sample");

    // error result is marked as the final result
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_spread_error |-> out_data.last_out)
        else $error("error result not marked last");

    // error result carries zero payload
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_spread_error |->
            out_data.element_out == '0 && out_data.statistic == '0)
        else $error("error result with nonzero payload");

endmodule

bind vector_standardizer_core vs_checker u_vs_checker (.*);
